[rtl/core/aer_pkg.sv]
// shared types, command codes and round helpers for the aes encryption round block
// s-box table, xtime and column mix functions used by the round logic
// no dependencies
package aer_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [31:0]  word_t;
  typedef logic [7:0]   byte_t;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ROUND = 2'd1,
    CMD_FINAL = 2'd2
  } cmd_e;

  // one request as held in the input stage
  typedef struct packed {
    logic [1:0] cmd;
    blk_t       block;
    blk_t       key;
  } req_t;

  localparam byte_t SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // multiply by x in gf(2^8)
  function automatic byte_t xtime(byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // mixcolumns on one column, row 0 byte in the top bits
  function automatic word_t mix_column(word_t w);
    byte_t a0, a1, a2, a3;
    byte_t r0, r1, r2, r3;
    a0 = w[31:24];
    a1 = w[23:16];
    a2 = w[15:8];
    a3 = w[7:0];
    r0 = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
    r1 = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
    r2 = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
    r3 = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    return {r0, r1, r2, r3};
  endfunction

endpackage

[rtl/core/aer_if.sv]
// valid/ready channel interfaces for the aes encryption round block
// request channel carries command, block and round key; response carries state
// no dependencies
interface aer_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic [63:0] round_key_high;
  logic [63:0] round_key_low;

  modport source (
    output valid, cmd, block_high, block_low, round_key_high, round_key_low,
    input  ready
  );
  modport sink (
    input  valid, cmd, block_high, block_low, round_key_high, round_key_low,
    output ready
  );
endinterface

interface aer_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic        is_final;

  modport source (
    output valid, result_high, result_low, is_final,
    input  ready
  );
  modport sink (
    input  valid, result_high, result_low, is_final,
    output ready
  );
endinterface

[rtl/core/aes_encrypt_round_top.sv]
// top level of the aes-128 encryption round block
// depends on aer_pkg, aer_req_if / aer_rsp_if and aer_round
//
// usage
//   req_i is a valid/ready channel; each request picks one operation by cmd:
//   load (block xor key), full round, or final round (no mixcolumns). the round
//   key comes with every request; key schedule and round count live outside.
//   rsp_o returns the 128-bit state after every request, is_final set for the
//   final round. an unused cmd code leaves the state alone and echoes it.
// stages and throughput
//   an accepted request is registered in the input stage, and its round result
//   is registered into the response register when the input stage advances.
//   one request per cycle is sustained while rsp_o takes every response; the
//   round logic between input stage and state register is combinational.
// reset
//   clears the state to zero and empties both stages.
// stalls
//   the state register doubles as the response data, so while rsp_o is held
//   the input stage keeps one request and req_i.ready drops once it is full.
module aes_encrypt_round_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  aer_req_if.sink   req_i,
  aer_rsp_if.source rsp_o
);
  import aer_pkg::*;

  req_t in_q;
  logic in_vld_q;
  logic out_vld_q;
  logic final_q;
  blk_t state_q;
  blk_t state_d;
  logic advance;

  // input stage moves on when the response slot is empty or being drained
  assign advance     = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.cmd   <= req_i.cmd;
      in_q.block <= {req_i.block_high, req_i.block_low};
      in_q.key   <= {req_i.round_key_high, req_i.round_key_low};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  aer_round u_round (
    .cmd_i   (in_q.cmd),
    .state_i (state_q),
    .block_i (in_q.block),
    .key_i   (in_q.key),
    .state_o (state_d)
  );

  // state register, also the response payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
      final_q   <= 1'b0;
    end else if (advance) begin
      state_q   <= state_d;
      out_vld_q <= 1'b1;
      final_q   <= (in_q.cmd == CMD_FINAL);
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.result_high = state_q[127:64];
  assign rsp_o.result_low  = state_q[63:0];
  assign rsp_o.is_final    = final_q;

`ifndef NO_ASSERTIONS
  // a held request must not touch the state
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> $stable(state_q))
    else $error("state changed without a request advancing");

  // a stalled response keeps the state, since the state is the payload
  a_stall_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !rsp_o.ready |=> $stable(state_q))
    else $error("state changed under a stalled response");

  // every advancing request produces a response
  a_adv_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced request left no response");

  // final flag follows the command of the advancing request
  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (final_q == ($past(in_q.cmd) == CMD_FINAL)))
    else $error("final flag does not match command");
`endif

endmodule

[rtl/core/aer_round.sv]
// combinational aes round: load, full round, final round or hold
// depends on aer_pkg for the s-box, column mix and command codes
module aer_round (
  input  logic [1:0]    cmd_i,
  input  aer_pkg::blk_t state_i,
  input  aer_pkg::blk_t block_i,
  input  aer_pkg::blk_t key_i,
  output aer_pkg::blk_t state_o
);
  import aer_pkg::*;

  word_t s_w   [4];
  word_t sub_w [4];
  word_t mix_w [4];
  blk_t  sub_blk;
  blk_t  mix_blk;

  // subbytes and shiftrows: row r of column c comes from column c+r, then mixcolumns
  for (genvar c = 0; c < 4; c++) begin : g_col
    assign s_w[c] = state_i[127-32*c -: 32];
    for (genvar r = 0; r < 4; r++) begin : g_row
      assign sub_w[c][31-8*r -: 8] = SBOX[s_w[(c+r)%4][31-8*r -: 8]];
    end
    assign mix_w[c] = mix_column(sub_w[c]);
    assign sub_blk[127-32*c -: 32] = sub_w[c];
    assign mix_blk[127-32*c -: 32] = mix_w[c];
  end

  always_comb begin
    unique case (cmd_i)
      CMD_LOAD:  state_o = block_i ^ key_i;
      CMD_ROUND: state_o = mix_blk ^ key_i;
      CMD_FINAL: state_o = sub_blk ^ key_i;
      default:   state_o = state_i;
    endcase
  end

endmodule

[bench/tb_top.sv]
// self-checking testbench for aes_encrypt_round_top: directed, random and stall tests
// keeps its own round predictor with an s-box derived from gf(2^8) inversion
// depends on aer_pkg, aer_req_if / aer_rsp_if and the rtl top level
`timescale 1ns / 1ps

module tb_top;
  import aer_pkg::*;

  // cmd code that the block leaves unused, echoes the state
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // full rounds between load and final round in aes-128
  localparam int NUM_FULL_ROUNDS = 9;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        fin;
  } cipher_rsp_t;

  logic clk_i;
  logic rst_ni;

  aer_req_if req_if ();
  aer_rsp_if rsp_if ();

  aes_encrypt_round_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // predictor state: s-box table and the cipher state as the block should hold it
  byte_t       sbox_tab [256];
  logic [63:0] cipher_hi;
  logic [63:0] cipher_lo;

  // states still to come back from the block, oldest first
  cipher_rsp_t expected_states [$];

  int fail_count;
  int req_count;
  int req_idle_pct;
  int rsp_stall_pct;
  int rsp_hold_cycles;

  // ---------------------------------------------------------------------------
  // gf(2^8) arithmetic and the round predictor
  // ---------------------------------------------------------------------------

  function automatic byte_t gf_double(byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = gf_double(a);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic byte_t rotl8(byte_t b, int k);
    return (b << k) | (b >> (8 - k));
  endfunction

  // s-box: multiplicative inverse (x^254, zero maps to zero) then the affine map
  function automatic void build_sbox();
    byte_t inv;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int n = 0; n < 254; n++) inv = gf_mul(inv, byte_t'(x));
      sbox_tab[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                    ^ 8'h63;
    end
  endfunction

  // mixcolumns of one column word, row 0 byte in bits 31..24
  function automatic word_t mix_col(word_t w);
    byte_t a [4];
    byte_t d [4];
    for (int r = 0; r < 4; r++) begin
      a[r] = w[31 - 8 * r -: 8];
      d[r] = gf_double(a[r]);
    end
    return {d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3],
            a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3],
            a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3],
            d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3]};
  endfunction

  // applies one request to the predicted state and returns the state to expect
  function automatic cipher_rsp_t apply_round(logic [1:0] cmd, logic [63:0] blk_hi,
                                              logic [63:0] blk_lo, logic [63:0] key_hi,
                                              logic [63:0] key_lo);
    word_t       s [4];
    word_t       t [4];
    word_t       k [4];
    cipher_rsp_t res;
    if (cmd == CMD_LOAD) begin
      cipher_hi = blk_hi;
      cipher_lo = blk_lo;
    end
    s = '{cipher_hi[63:32], cipher_hi[31:0], cipher_lo[63:32], cipher_lo[31:0]};
    k = '{key_hi[63:32], key_hi[31:0], key_lo[63:32], key_lo[31:0]};
    if (cmd != CMD_UNUSED) begin
      if (cmd != CMD_LOAD) begin
        // subbytes and shiftrows: row r of column c comes from column c+r
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            t[c][31 - 8 * r -: 8] = sbox_tab[s[(c + r) % 4][31 - 8 * r -: 8]];
        s = t;
        if (cmd == CMD_ROUND)
          for (int c = 0; c < 4; c++) s[c] = mix_col(s[c]);
      end
      for (int c = 0; c < 4; c++) s[c] ^= k[c];
      cipher_hi = {s[0], s[1]};
      cipher_lo = {s[2], s[3]};
    end
    res.hi  = cipher_hi;
    res.lo  = cipher_lo;
    res.fin = (cmd == CMD_FINAL);
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset and time limit
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // every input known from time zero
  initial begin
    rst_ni                = 1'b0;
    req_if.valid          = 1'b0;
    req_if.cmd            = CMD_LOAD;
    req_if.block_high     = '0;
    req_if.block_low      = '0;
    req_if.round_key_high = '0;
    req_if.round_key_low  = '0;
    rsp_if.ready          = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("aes_encrypt_round_top regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // response side: random stalls, long hold-off on demand, and the state check
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin : state_check
        cipher_rsp_t exp;
        if (expected_states.size() == 0) begin
          $error("response with no request pending: %h %h final %b",
                 rsp_if.result_high, rsp_if.result_low, rsp_if.is_final);
          fail_count++;
        end else begin
          exp = expected_states.pop_front();
          if (rsp_if.result_high !== exp.hi) begin
            $error("result_high: expected %h, got %h", exp.hi, rsp_if.result_high);
            fail_count++;
          end
          if (rsp_if.result_low !== exp.lo) begin
            $error("result_low: expected %h, got %h", exp.lo, rsp_if.result_low);
            fail_count++;
          end
          if (rsp_if.is_final !== exp.fin) begin
            $error("is_final: expected %b, got %b", exp.fin, rsp_if.is_final);
            fail_count++;
          end
        end
      end
      // a hold-off request overrides the random stall pattern
      if (rsp_hold_cycles > 0) begin
        rsp_hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offers one request after a random idle gap and records its prediction once
  // it is accepted; returns in the step of the accepting edge
  task automatic send_req(logic [1:0] cmd, logic [63:0] blk_hi, logic [63:0] blk_lo,
                          logic [63:0] key_hi, logic [63:0] key_lo);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.cmd            <= cmd;
    req_if.block_high     <= blk_hi;
    req_if.block_low      <= blk_lo;
    req_if.round_key_high <= key_hi;
    req_if.round_key_low  <= key_lo;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    expected_states.push_back(apply_round(cmd, blk_hi, blk_lo, key_hi, key_lo));
    req_count++;
  endtask

  // load, a number of full rounds, then the final round when with_final is set;
  // random keys and, on the rounds, random block fields that the block must ignore
  task automatic send_encryption(int full_rounds, bit with_final);
    send_req(CMD_LOAD, rand64(), rand64(), rand64(), rand64());
    for (int i = 0; i < full_rounds; i++)
      send_req(CMD_ROUND, rand64(), rand64(), rand64(), rand64());
    if (with_final) send_req(CMD_FINAL, rand64(), rand64(), rand64(), rand64());
  endtask

  task automatic send_noise();
    send_req(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
  endtask

  // drops valid in the accepting step, then waits until every state has come back
  task automatic wait_all_returned();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_states.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    // rounds before any load act on the zero state left by reset
    send_req(CMD_ROUND, '0, '0, '0, '0);
    send_req(CMD_FINAL, '1, '1, '1, '1);
    // unused command echoes the state, ignores the key, clears is_final
    send_req(CMD_UNUSED, '1, '1, rand64(), rand64());
    // loads at the extremes of block and key
    send_req(CMD_LOAD, '0, '0, '0, '0);
    send_req(CMD_LOAD, '1, '1, '0, '0);
    send_req(CMD_LOAD, '0, '0, '1, '1);
    send_req(CMD_ROUND, '0, '0, '1, '1);
    // standard aes-128 example block and first two round keys
    send_req(CMD_LOAD, 64'h3243f6a8885a308d, 64'h313198a2e0370734,
             64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_req(CMD_ROUND, '1, '1, 64'ha0fafe1788542cb1, 64'h23a339392a6c7605);
    send_req(CMD_FINAL, '1, '0, rand64(), rand64());
    // after the final round the state keeps going
    send_req(CMD_UNUSED, '0, '1, '1, '1);
    send_req(CMD_ROUND, rand64(), rand64(), rand64(), rand64());
    send_req(CMD_LOAD, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
             64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_req(CMD_FINAL, '1, '1, '0, '0);
    send_req(CMD_UNUSED, '1, '1, '1, '1);
  endtask

  // mostly whole encryptions, the rest broken sequences and random commands
  task automatic test_random_phases();
    int idle_pct  [4] = '{0, 80, 0, 34};
    int stall_pct [4] = '{0, 0, 80, 34};
    int phase_end;
    int pick;
    for (int p = 0; p < 4; p++) begin
      req_idle_pct  = idle_pct[p];
      rsp_stall_pct = stall_pct[p];
      phase_end     = req_count + ITEMS_PER_PHASE;
      while (req_count < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 75) send_encryption(NUM_FULL_ROUNDS, 1'b1);
        else if (pick < 88) send_encryption(int'($urandom_range(NUM_FULL_ROUNDS)),
                                            1'($urandom_range(1)));
        else repeat ($urandom_range(1, 3)) send_noise();
      end
    end
  endtask

  // receiver holds off long enough for both stages to fill and req ready to drop
  task automatic test_output_hold();
    req_idle_pct    = 0;
    rsp_stall_pct   = 0;
    rsp_hold_cycles = 150;
    send_encryption(NUM_FULL_ROUNDS, 1'b1);
    send_encryption(NUM_FULL_ROUNDS, 1'b1);
  endtask

  // sender pauses until the block has returned everything, then resumes
  task automatic test_drain_pause();
    req_idle_pct  = 34;
    rsp_stall_pct = 34;
    send_encryption(3, 1'b0);
    wait_all_returned();
    send_req(CMD_ROUND, rand64(), rand64(), rand64(), rand64());
    send_req(CMD_FINAL, rand64(), rand64(), rand64(), rand64());
  endtask

  // ---------------------------------------------------------------------------
  // sequence of tests and the verdict
  // ---------------------------------------------------------------------------

  initial begin
    fail_count      = 0;
    req_count       = 0;
    req_idle_pct    = 0;
    rsp_stall_pct   = 0;
    rsp_hold_cycles = 0;
    cipher_hi       = '0;
    cipher_lo       = '0;
    build_sbox();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phases();
    test_output_hold();
    test_drain_pause();

    // let the pipeline empty, then give stray responses a chance to show up
    rsp_stall_pct = 0;
    wait_all_returned();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && expected_states.size() == 0) begin
      $display("aes_encrypt_round_top regression: pass");
    end else begin
      $display("aes_encrypt_round_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/aer_pkg.sv
rtl/core/aer_if.sv
rtl/core/aer_round.sv
rtl/core/aes_encrypt_round_top.sv
bench/tb_top.sv
